FILE: src/i2a_pkg.sv
// i2a_pkg: shared types and constants for the integer to ASCII converter.
// No dependencies; every module of the block refers to it by scoped names.
`timescale 1ns / 1ps

package i2a_pkg;

    // Format command codes
    localparam logic [1:0] CMD_SIGNED_DEC   = 2'd0;
    localparam logic [1:0] CMD_UNSIGNED_DEC = 2'd1;
    localparam logic [1:0] CMD_HEX          = 2'd2;

    // ASCII characters used in the output string
    localparam logic [7:0] ASCII_MINUS = 8'h2d;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_LC_A  = 8'h61;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic valid;
    } t_q_status;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_NORM,
        ST_SIGN,
        ST_EMIT
    } t_back_state;

endpackage

FILE: src/i2a_front.sv
// i2a_front: accepts a word and a command, registers the classified item
// (magnitude, hex flag, negative flag) and hands it to the queue. Uses i2a_pkg.
`timescale 1ns / 1ps

module i2a_front #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  logic [1:0]             i_command,
    input  i2a_pkg::t_q_status     i_q,
    output logic                   o_busy,
    output logic                   o_push,
    output logic [VALUE_WIDTH+1:0] o_item
);

    logic                   r_valid;
    logic [VALUE_WIDTH-1:0] r_mag;
    logic                   r_hex;
    logic                   r_neg;
    logic                   n_valid;
    logic [VALUE_WIDTH-1:0] n_mag;
    logic                   n_hex;
    logic                   n_neg;
    logic                   accept;
    logic                   is_neg;

    // Holding register frees up whenever the queue takes its item
    assign o_busy = r_valid && i_q.full;
    assign o_push = r_valid && !i_q.full;
    assign accept = i_start && !o_busy;
    assign o_item = {r_neg, r_hex, r_mag};

    // Classify: sign only matters in signed decimal, hex selects radix 16
    assign is_neg = (i_command == i2a_pkg::CMD_SIGNED_DEC) && i_value[VALUE_WIDTH-1];

    always_comb begin
        n_valid = r_valid;
        n_mag   = r_mag;
        n_hex   = r_hex;
        n_neg   = r_neg;
        if (o_push) begin
            n_valid = 1'b0;
        end
        if (accept) begin
            n_valid = 1'b1;
            n_hex   = (i_command == i2a_pkg::CMD_HEX);
            n_neg   = is_neg;
            n_mag   = is_neg ? (~i_value + VALUE_WIDTH'(1)) : i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_mag <= n_mag;
        r_hex <= n_hex;
        r_neg <= n_neg;
    end

endmodule

FILE: src/i2a_queue.sv
// i2a_queue: two-entry item queue between the front and the back end.
// Uses i2a_pkg for the status struct.
`timescale 1ns / 1ps

module i2a_queue #(
    parameter int WIDTH = 34
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [WIDTH-1:0]   i_item,
    input  logic               i_pop,
    output logic [WIDTH-1:0]   o_item,
    output i2a_pkg::t_q_status o_status
);

    localparam int DEPTH = 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr;
    logic [AW-1:0]    r_rptr;
    logic [CW-1:0]    r_count;
    logic [AW-1:0]    n_wptr;
    logic [AW-1:0]    n_rptr;
    logic [CW-1:0]    n_count;
    logic             do_push;
    logic             do_pop;

    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.valid = (r_count != '0);
    assign o_item         = r_mem[r_rptr];
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && o_status.valid;

    // Pointer wrap and occupancy
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
        if (do_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

FILE: src/i2a_back.sv
// i2a_back: converts one queued item to digits (shift-and-add-3, four bits
// a cycle, decimal), drops leading zeros, sends characters. Uses i2a_pkg.
`timescale 1ns / 1ps

module i2a_back #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  i2a_pkg::t_q_status     i_q,
    input  logic [VALUE_WIDTH+1:0] i_item,
    output logic                   o_pop,
    output logic                   o_strobe,
    output logic [7:0]             o_out_char,
    output logic                   o_last
);

    // Digit counts: decimal digits of the largest word, hex nibbles
    localparam int NDEC = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int NHEX = (VALUE_WIDTH + 3) / 4;
    localparam int NDIG = (NDEC > NHEX) ? NDEC : NHEX;
    localparam int WP   = NHEX * 4;
    localparam int DW   = NDIG * 4;
    localparam int CW   = $clog2(NDIG + 1);
    localparam int IW   = $clog2(NHEX + 1);
    localparam int SKIP_MAX = (NDIG < 4) ? NDIG : 4;

    i2a_pkg::t_back_state r_state;
    i2a_pkg::t_back_state n_state;

    logic [DW-1:0]  r_dig;
    logic [WP-1:0]  r_bin;
    logic [CW-1:0]  r_cnt;
    logic [IW-1:0]  r_iter;
    logic           r_neg;
    logic           r_strobe;
    logic [7:0]     r_char;
    logic           r_last;
    logic [DW-1:0]  n_dig;
    logic [WP-1:0]  n_bin;
    logic [CW-1:0]  n_cnt;
    logic [IW-1:0]  n_iter;
    logic           n_neg;
    logic           n_strobe;
    logic [7:0]     n_char;
    logic           n_last;

    logic [DW+WP-1:0] dab;
    logic [2:0]       skip;
    logic             zero_run;
    logic [3:0]       top_digit;

    function automatic logic [7:0] to_ascii(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = i2a_pkg::ASCII_ZERO + {4'd0, d};
        end else begin
            c = i2a_pkg::ASCII_LC_A + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

    assign top_digit  = r_dig[DW-1 -: 4];
    assign o_strobe   = r_strobe;
    assign o_out_char = r_char;
    assign o_last     = r_last;

    // Four shift-and-add-3 steps on the digit and binary registers
    always_comb begin
        dab = {r_dig, r_bin};
        for (int s = 0; s < 4; s++) begin
            for (int j = 0; j < NDIG; j++) begin
                if (dab[WP + 4*j +: 4] >= 4'd5) begin
                    dab[WP + 4*j +: 4] = dab[WP + 4*j +: 4] + 4'd3;
                end
            end
            dab = dab << 1;
        end
    end

    // Leading zeros dropped up to four a cycle, always keeping one digit
    always_comb begin
        zero_run = 1'b1;
        skip     = 3'd0;
        for (int k = 0; k < SKIP_MAX; k++) begin
            zero_run = zero_run && (r_dig[4*(NDIG-1-k) +: 4] == 4'd0);
            if (zero_run && (CW'(k + 1) < r_cnt)) begin
                skip = 3'(k + 1);
            end
        end
    end

    // Sequencer: next state and outputs
    always_comb begin
        n_state  = r_state;
        n_dig    = r_dig;
        n_bin    = r_bin;
        n_cnt    = r_cnt;
        n_iter   = r_iter;
        n_neg    = r_neg;
        n_strobe = 1'b0;
        n_char   = r_char;
        n_last   = r_last;
        o_pop    = 1'b0;
        unique case (r_state)
            i2a_pkg::ST_IDLE: begin
                if (i_q.valid) begin
                    o_pop  = 1'b1;
                    n_neg  = i_item[VALUE_WIDTH+1];
                    n_cnt  = CW'(NDIG);
                    n_iter = IW'(NHEX);
                    if (i_item[VALUE_WIDTH]) begin
                        n_dig   = DW'(WP'(i_item[VALUE_WIDTH-1:0]));
                        n_state = i2a_pkg::ST_NORM;
                    end else begin
                        n_dig   = '0;
                        n_bin   = WP'(i_item[VALUE_WIDTH-1:0]);
                        n_state = i2a_pkg::ST_CONV;
                    end
                end
            end
            i2a_pkg::ST_CONV: begin
                n_dig  = dab[DW+WP-1 -: DW];
                n_bin  = dab[WP-1:0];
                n_iter = r_iter - IW'(1);
                if (r_iter == IW'(1)) begin
                    n_state = i2a_pkg::ST_NORM;
                end
            end
            i2a_pkg::ST_NORM: begin
                if (skip != 3'd0) begin
                    n_dig = r_dig << (4 * skip);
                    n_cnt = r_cnt - CW'(skip);
                end else if (r_neg) begin
                    n_state = i2a_pkg::ST_SIGN;
                end else begin
                    n_state = i2a_pkg::ST_EMIT;
                end
            end
            i2a_pkg::ST_SIGN: begin
                n_strobe = 1'b1;
                n_char   = i2a_pkg::ASCII_MINUS;
                n_last   = 1'b0;
                n_state  = i2a_pkg::ST_EMIT;
            end
            i2a_pkg::ST_EMIT: begin
                n_strobe = 1'b1;
                n_char   = to_ascii(top_digit);
                n_last   = (r_cnt == CW'(1));
                n_dig    = r_dig << 4;
                n_cnt    = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_state = i2a_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = i2a_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= i2a_pkg::ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
        r_dig  <= n_dig;
        r_bin  <= n_bin;
        r_cnt  <= n_cnt;
        r_iter <= n_iter;
        r_neg  <= n_neg;
        r_char <= n_char;
        r_last <= n_last;
    end

endmodule

FILE: src/int_to_ascii_digits.sv
// int_to_ascii_digits: top level of the binary to ASCII decimal/hex converter.
// Instantiates i2a_front, i2a_queue and i2a_back; uses i2a_pkg.
`timescale 1ns / 1ps

// Channel   Ports                          Handshake
// input     i_value, i_command             taken at a clock edge with start high, busy low
// result    o_out_char, o_last             one cycle each while o_strobe is high
//
// A word waits in the front register, then in a two-entry queue.
// Decimal: the item is loaded and converted by shift-and-add-3, then leading zero
// digits are dropped up to four per cycle, then one character is sent per cycle.
// Hex skips the shift-and-add-3 conversion. The back-end sequencer sets the rate.
// Reset (i_rst_n low at a clock edge) empties the queue and stops any string.
// The receiver cannot stall; busy rises only when the front and queue are full.

module int_to_ascii_digits #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  logic [1:0]             i_command,
    output logic                   o_strobe,
    output logic [7:0]             o_out_char,
    output logic                   o_last
);

    i2a_pkg::t_q_status     q_status;
    logic                   push;
    logic                   pop;
    logic [VALUE_WIDTH+1:0] front_item;
    logic [VALUE_WIDTH+1:0] queue_item;

    i2a_front #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_value   (i_value),
        .i_command (i_command),
        .i_q       (q_status),
        .o_busy    (busy),
        .o_push    (push),
        .o_item    (front_item)
    );

    i2a_queue #(
        .WIDTH(VALUE_WIDTH + 2)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (front_item),
        .i_pop    (pop),
        .o_item   (queue_item),
        .o_status (q_status)
    );

    i2a_back #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q        (q_status),
        .i_item     (queue_item),
        .o_pop      (pop),
        .o_strobe   (o_strobe),
        .o_out_char (o_out_char),
        .o_last     (o_last)
    );

endmodule

FILE: sim/int_to_ascii_digits_test.sv
// int_to_ascii_digits_test: self-checking bench for the integer to ASCII converter.
// Drives words in all format commands and checks every character strobe.
// Depends on i2a_pkg and int_to_ascii_digits.
`timescale 1ns / 1ps

module int_to_ascii_digits_test;

    localparam int VW          = 32;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;
    localparam int QUIET_ITEMS = 40;
    localparam int RAND_ITEMS  = 250;
    localparam int MAX_SHOWN   = 10;

    // The spare command code has no package name; it formats as unsigned decimal
    localparam logic [1:0] CMD_SPARE = 2'd3;

    typedef struct {
        logic [VW-1:0] value;
        logic [1:0]    cmd;
        bit            settle;    // hold until every pending character is out
    } t_word_item;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_char;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start = 1'b0;
    logic [VW-1:0] i_value = '0;
    logic [1:0]    i_command = i2a_pkg::CMD_SIGNED_DEC;
    logic          busy;
    logic          o_strobe;
    logic [7:0]    o_out_char;
    logic          o_last;

    t_word_item word_queue[$];
    t_char      exp_chars[$];
    t_word_item next_word;
    t_char      want;

    int total_items  = 0;
    int accepted_cnt = 0;
    int gap_left     = 0;
    int stall_cycles = 0;
    int errors       = 0;

    int_to_ascii_digits #(
        .VALUE_WIDTH(VW)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_value    (i_value),
        .i_command  (i_command),
        .o_strobe   (o_strobe),
        .o_out_char (o_out_char),
        .o_last     (o_last)
    );

    // 10 ns clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Expected character string of one word, most significant first
    task automatic predict_digits(input logic [VW-1:0] value, input logic [1:0] cmd);
        logic [VW-1:0] mag;
        logic [VW-1:0] radix;
        logic [VW-1:0] rem;
        logic [7:0]    rev[$];
        bit            neg;
        mag   = value;
        radix = 10;
        neg   = 1'b0;
        if (cmd == i2a_pkg::CMD_SIGNED_DEC) begin
            if (value[VW-1]) begin
                neg = 1'b1;
                mag = -value;
            end
        end else if (cmd == i2a_pkg::CMD_HEX) begin
            radix = 16;
        end
        // digits come out least significant first
        do begin
            rem = mag % radix;
            rev.push_back(rem < 10 ? i2a_pkg::ASCII_ZERO + rem[7:0]
                                   : i2a_pkg::ASCII_LC_A + rem[7:0] - 8'd10);
            mag = mag / radix;
        end while (mag != 0);
        if (neg) begin
            exp_chars.push_back('{ch: i2a_pkg::ASCII_MINUS, last: 1'b0});
        end
        for (int i = rev.size() - 1; i >= 0; i--) begin
            exp_chars.push_back('{ch: rev[i], last: (i == 0)});
        end
    endtask

    task automatic add_word(input logic [VW-1:0] value, input logic [1:0] cmd,
                            input bit settle = 1'b0);
        word_queue.push_back('{value: value, cmd: cmd, settle: settle});
    endtask

    // Random word: small, shortened, negative, near a power of ten, or full width
    function automatic logic [VW-1:0] pick_value();
        logic [VW-1:0] v;
        logic [VW-1:0] p;
        int            k;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 99);
            1: v = $urandom >> $urandom_range(0, VW - 1);
            2: v = -$urandom_range(0, 1000);
            3: begin
                p = 1;
                k = $urandom_range(0, 9);
                for (int i = 0; i < k; i++) p = p * 10;
                v = p + $urandom_range(0, 2) - 1;
                if ($urandom_range(0, 1)) v = -v;
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [1:0] pick_command();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3) return i2a_pkg::CMD_SIGNED_DEC;
        if (sel < 6) return i2a_pkg::CMD_UNSIGNED_DEC;
        if (sel < 9) return i2a_pkg::CMD_HEX;
        return CMD_SPARE;
    endfunction

    // Driver: presents queued words, holds while busy, inserts idle bursts
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                predict_digits(i_value, i_command);
                accepted_cnt++;
                if (accepted_cnt < total_items - QUIET_ITEMS && $urandom_range(0, 3) == 0) begin
                    gap_left = $urandom_range(1, 12);
                end
            end
            if (start && busy) begin
                // hold the item until taken
            end else if (gap_left > 0) begin
                gap_left--;
                start     <= 1'b0;
                i_value   <= $urandom;
                i_command <= 2'($urandom_range(0, 3));
            end else if (word_queue.size() > 0 &&
                         !(word_queue[0].settle && exp_chars.size() != 0)) begin
                next_word  = word_queue.pop_front();
                start     <= 1'b1;
                i_value   <= next_word.value;
                i_command <= next_word.cmd;
            end else begin
                start     <= 1'b0;
                i_value   <= $urandom;
                i_command <= 2'($urandom_range(0, 3));
            end
        end
    end

    // Monitor: compares each strobed character with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe) stall_cycles = 0;
            else stall_cycles++;
            if (o_strobe) begin
                if (exp_chars.size() == 0) begin
                    errors++;
                    if (errors <= MAX_SHOWN) begin
                        $display("unexpected char %h last=%b at %0t", o_out_char, o_last,
                                 $realtime);
                    end
                end else begin
                    want = exp_chars.pop_front();
                    if (o_out_char !== want.ch || o_last !== want.last) begin
                        errors++;
                        if (errors <= MAX_SHOWN) begin
                            $display("char mismatch at %0t: expected %h last=%b, got %h last=%b",
                                     $realtime, want.ch, want.last, o_out_char, o_last);
                        end
                    end
                end
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        // zero in every format
        add_word('0, i2a_pkg::CMD_SIGNED_DEC);
        add_word('0, i2a_pkg::CMD_UNSIGNED_DEC);
        add_word('0, i2a_pkg::CMD_HEX);
        add_word('0, CMD_SPARE);
        // all ones in every format
        add_word('1, i2a_pkg::CMD_SIGNED_DEC);
        add_word('1, i2a_pkg::CMD_UNSIGNED_DEC);
        add_word('1, i2a_pkg::CMD_HEX);
        add_word('1, CMD_SPARE);
        // most negative word and the largest positive one
        add_word(32'h8000_0000, i2a_pkg::CMD_SIGNED_DEC);
        add_word(32'h8000_0000, i2a_pkg::CMD_UNSIGNED_DEC);
        add_word(32'h8000_0000, i2a_pkg::CMD_HEX);
        add_word(32'h7fff_ffff, i2a_pkg::CMD_SIGNED_DEC);
        // digit count boundaries
        add_word(32'd1, i2a_pkg::CMD_SIGNED_DEC);
        add_word(32'd9, i2a_pkg::CMD_SIGNED_DEC);
        add_word(32'd10, i2a_pkg::CMD_SIGNED_DEC);
        add_word(32'd15, i2a_pkg::CMD_HEX);
        add_word(32'd16, i2a_pkg::CMD_HEX);
        add_word(32'habcd_ef01, i2a_pkg::CMD_HEX);
        add_word(32'd999_999_999, i2a_pkg::CMD_UNSIGNED_DEC);
        add_word(32'd1_000_000_000, i2a_pkg::CMD_UNSIGNED_DEC);
        add_word(32'hffff_fff6, i2a_pkg::CMD_SIGNED_DEC);
        add_word(32'hfedc_ba98, CMD_SPARE);

        // random words; two of them wait for a fully drained block
        for (int i = 0; i < RAND_ITEMS; i++) begin
            add_word(pick_value(), pick_command(), (i == 0) || (i == RAND_ITEMS / 2));
        end
        total_items = word_queue.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while ((accepted_cnt < total_items || exp_chars.size() != 0) &&
               stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
        end

        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            // catch any stray strobes after the last expected character
            repeat (TAIL_CYCLES) @(posedge i_clk);
            if (errors == 0) begin
                $display("[ OK ] regression clean");
            end else begin
                $display("[FAIL] regression broken");
            end
            $finish;
        end
    end

endmodule
